/* hw/rtl/slac_pkg.sv */
// Shared types, widths and codes for the set-associative LRU key cache.
`timescale 1ns / 1ps
package slac_pkg;
	localparam int SETS_DEF = 16;
	localparam int WAYS_DEF = 4;

	localparam int KEY_W    = 31;
	localparam int VAL_W    = 32;
	localparam int STAMP_W  = 32;
	localparam int CMD_W    = 2;
	localparam int KIND_W   = 2;
	localparam int S_DATA_W = 64;
	localparam int ENTRY_W  = 1 + KEY_W + VAL_W + STAMP_W;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SHOOT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DROP  = 2'd3;

	localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_HIT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MISS  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_EVICT = 2'd3;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [STAMP_W-1:0] stamp;
	} entry_t;
endpackage

/* hw/rtl/slac_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module slac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/slac_setmod.sv */
// Multi-cycle key modulo SETS unit, eight remainder steps per cycle.
`timescale 1ns / 1ps
module slac_setmod #(
	parameter int SETS = slac_pkg::SETS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [slac_pkg::KEY_W-1:0]             key,
	output logic                                   done,
	output logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] set_idx
);
	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int R_W   = $clog2(SETS) + 1;
	localparam int STEPS = 8;

	logic [R_W-1:0] r_q;
	logic [R_W-1:0] r_next;
	logic [31:0]    sh_q;
	logic [1:0]     cnt_q;
	logic           busy_q;
	logic           done_q;

	always_comb begin
		logic [R_W:0]   tmp;
		logic [R_W-1:0] t;
		t = r_q;
		for (int i = 0; i < STEPS; i++) begin
			tmp = {t, sh_q[31 - i]};
			t   = tmp[R_W-1:0];
			if (t >= R_W'(SETS)) begin
				t = t - R_W'(SETS);
			end
		end
		r_next = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= '0;
			sh_q <= {1'b0, key};
		end else if (busy_q) begin
			r_q  <= r_next;
			sh_q <= {sh_q[23:0], 8'd0};
		end
	end

	assign done    = done_q;
	assign set_idx = r_q[SET_W-1:0];
endmodule

/* hw/rtl/set_assoc_lru_key_cache.sv */
// Set-associative key/value cache with timestamp LRU replacement, top level.
`timescale 1ns / 1ps
// One row of the tag RAM holds all WAYS entries of a set. After reset the block
// clears every RAM row in turn before it accepts its first item. Add, find and
// shootdown step from one accepted item to the next through the accept state, the
// reduction of the key modulo SETS, a RAM read, a load, a scan of the set one way
// at a time (match, first free way and oldest stamp), and a write-back, which waits
// while the output register is full. Drop takes the accept state, then walks every
// set in order through read, load, scan and write-back, then a final state for the
// flagged result; a report waits while the output is stalled. The output register
// lets one result wait for the sink while the next item is already accepted.
module set_assoc_lru_key_cache #(
	parameter int SETS = slac_pkg::SETS_DEF,
	parameter int WAYS = slac_pkg::WAYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_data,   // evict_notify
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [slac_pkg::S_DATA_W-1:0] s_tdata,    // key[30:0], value[62:31], zero pad
	input  logic [slac_pkg::CMD_W-1:0]    s_tuser,    // cmd[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [slac_pkg::VAL_W-1:0]    m_tdata,    // result_value[31:0]
	output logic [slac_pkg::KIND_W-1:0]   m_tuser,    // kind[1:0]
	output logic                          m_tlast
);
	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W = WAYS * slac_pkg::ENTRY_W;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_LOAD  = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;
	localparam logic [2:0] ST_WB    = 3'd6;
	localparam logic [2:0] ST_FINAL = 3'd7;

	logic [2:0] st_q;
	logic [SET_W-1:0] clr_q;
	logic [SET_W-1:0] set_q;
	logic [WAY_W-1:0] way_q;
	logic notify_q;
	logic [slac_pkg::STAMP_W-1:0] use_q;

	logic [slac_pkg::CMD_W-1:0] cmd_q;
	logic [slac_pkg::KEY_W-1:0] key_q;
	logic [slac_pkg::VAL_W-1:0] val_q;

	slac_pkg::entry_t [WAYS-1:0] row_q;
	slac_pkg::entry_t [WAYS-1:0] new_row;
	slac_pkg::entry_t            cur;
	logic [ROW_W-1:0] ram_rdata;

	logic free_q, hit_q;
	logic [WAY_W-1:0] free_way_q, hit_way_q, min_way_q;
	logic [slac_pkg::STAMP_W-1:0] min_q;
	logic pend_q;
	logic [slac_pkg::VAL_W-1:0] pend_val_q;

	logic mod_start, mod_done;
	logic [SET_W-1:0] mod_set;

	logic m_valid_q;
	logic [slac_pkg::VAL_W-1:0] m_data_q;
	logic [slac_pkg::KIND_W-1:0] m_kind_q;
	logic m_last_q;

	logic out_free;
	logic s_fire;
	logic scan_stall;
	logic wb_fire;
	logic ram_we;
	logic [WAY_W-1:0] slot;
	logic emit;
	logic [slac_pkg::KIND_W-1:0] emit_kind;
	logic [slac_pkg::VAL_W-1:0]  emit_val;
	logic emit_last;
	logic [ROW_W-1:0] ram_wdata;
	logic [SET_W-1:0] ram_waddr;

	assign cfg_ready = 1'b1;
	assign s_tready  = (st_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign mod_start = s_fire && (s_tuser != slac_pkg::CMD_DROP);
	assign cur       = row_q[way_q];

	slac_setmod #(.SETS(SETS)) u_setmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.key     (s_tdata[slac_pkg::KEY_W-1:0]),
		.done    (mod_done),
		.set_idx (mod_set)
	);

	// Drop holds back one reported value so the final one can carry last.
	assign scan_stall = (st_q == ST_SCAN) && (cmd_q == slac_pkg::CMD_DROP) && cur.valid
		&& notify_q && pend_q && !out_free;

	always_comb begin
		case (cmd_q)
			slac_pkg::CMD_ADD: slot = free_q ? free_way_q : min_way_q;
			default:           slot = hit_way_q;
		endcase
	end

	always_comb begin
		new_row = row_q;
		case (cmd_q)
			slac_pkg::CMD_ADD: begin
				new_row[slot].valid = 1'b1;
				new_row[slot].key   = key_q;
				new_row[slot].value = val_q;
				new_row[slot].stamp = use_q;
			end
			slac_pkg::CMD_FIND: begin
				if (hit_q) begin
					new_row[slot].stamp = use_q;
				end
			end
			slac_pkg::CMD_SHOOT: begin
				if (hit_q) begin
					new_row[slot].valid = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign wb_fire = (st_q == ST_WB) && ((cmd_q == slac_pkg::CMD_DROP) || out_free);

	always_comb begin
		emit      = 1'b0;
		emit_kind = slac_pkg::KIND_DONE;
		emit_val  = '0;
		emit_last = 1'b1;
		case (st_q)
			ST_SCAN: begin
				if (cmd_q == slac_pkg::CMD_DROP && cur.valid && notify_q && pend_q && out_free) begin
					emit      = 1'b1;
					emit_kind = slac_pkg::KIND_EVICT;
					emit_val  = pend_val_q;
					emit_last = 1'b0;
				end
			end
			ST_WB: begin
				if (cmd_q != slac_pkg::CMD_DROP && out_free) begin
					emit = 1'b1;
					case (cmd_q)
						slac_pkg::CMD_ADD: begin
							if (!free_q && notify_q) begin
								emit_kind = slac_pkg::KIND_EVICT;
								emit_val  = row_q[slot].value;
							end
						end
						slac_pkg::CMD_FIND: begin
							emit_kind = hit_q ? slac_pkg::KIND_HIT : slac_pkg::KIND_MISS;
							emit_val  = hit_q ? row_q[slot].value : '0;
						end
						default: begin
							if (hit_q && notify_q) begin
								emit_kind = slac_pkg::KIND_EVICT;
								emit_val  = row_q[slot].value;
							end
						end
					endcase
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = pend_q ? slac_pkg::KIND_EVICT : slac_pkg::KIND_DONE;
					emit_val  = pend_q ? pend_val_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_we    = (st_q == ST_CLEAR) || wb_fire;
	assign ram_waddr = (st_q == ST_CLEAR) ? clr_q : set_q;
	assign ram_wdata = (st_q == ST_CLEAR) ? '0 : ROW_W'(new_row);

	slac_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (set_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_CLEAR;
			clr_q     <= '0;
			notify_q  <= 1'b1;
			use_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				notify_q <= cfg_data;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(SETS - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_fire) begin
						st_q <= (s_tuser == slac_pkg::CMD_DROP) ? ST_READ : ST_MOD;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						st_q <= ST_READ;
					end
				end
				ST_READ: st_q <= ST_LOAD;
				ST_LOAD: st_q <= ST_SCAN;
				ST_SCAN: begin
					if (!scan_stall && way_q == WAY_W'(WAYS - 1)) begin
						st_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (wb_fire) begin
						if (cmd_q == slac_pkg::CMD_DROP) begin
							st_q <= (set_q == SET_W'(SETS - 1)) ? ST_FINAL : ST_READ;
						end else begin
							st_q <= ST_IDLE;
							if (cmd_q == slac_pkg::CMD_ADD
								|| (cmd_q == slac_pkg::CMD_FIND && hit_q)) begin
								use_q <= use_q + 1'b1;
							end
						end
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: captured item, set index, scan trackers, working row, output payload.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q  <= s_tuser;
			key_q  <= s_tdata[slac_pkg::KEY_W-1:0];
			val_q  <= s_tdata[slac_pkg::KEY_W +: slac_pkg::VAL_W];
			set_q  <= '0;
			pend_q <= 1'b0;
		end
		if (st_q == ST_MOD && mod_done) begin
			set_q <= mod_set;
		end
		if (st_q == ST_LOAD) begin
			row_q  <= ram_rdata;
			way_q  <= '0;
			free_q <= 1'b0;
			hit_q  <= 1'b0;
		end
		if (st_q == ST_SCAN && !scan_stall) begin
			way_q <= way_q + 1'b1;
			case (cmd_q)
				slac_pkg::CMD_ADD: begin
					if (!free_q && !cur.valid) begin
						free_q     <= 1'b1;
						free_way_q <= way_q;
					end
					if (way_q == '0 || cur.stamp < min_q) begin
						min_q     <= cur.stamp;
						min_way_q <= way_q;
					end
				end
				slac_pkg::CMD_DROP: begin
					if (cur.valid) begin
						row_q[way_q].valid <= 1'b0;
						if (notify_q) begin
							pend_q     <= 1'b1;
							pend_val_q <= cur.value;
						end
					end
				end
				default: begin
					if (!hit_q && cur.valid && cur.key == key_q) begin
						hit_q     <= 1'b1;
						hit_way_q <= way_q;
					end
				end
			endcase
		end
		if (wb_fire && cmd_q == slac_pkg::CMD_DROP) begin
			set_q <= set_q + 1'b1;
		end
		if (emit) begin
			m_data_q <= emit_val;
			m_kind_q <= emit_kind;
			m_last_q <= emit_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
endmodule
